>>> hdl/cvr_pkg.sv
// Shared types and constants for the 3x3 clamp-to-edge convolution block.
`timescale 1ns / 1ps
package cvr_pkg;

  // Field and register widths
  localparam int unsigned PixW         = 8;
  localparam int unsigned RowW         = 12;
  localparam int unsigned ValueW       = 28;
  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned CoefRowW     = 3 * CoefW;
  localparam int unsigned MaxHeight    = 4096;
  localparam int unsigned DefaultMaxWidth = 1024;

  // Config port
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;

  // Depth of the job queue between front and back
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegCoefAbove   = 3'd2,
    RegCoefCentre  = 3'd3,
    RegCoefBelow   = 3'd4
  } cvr_reg_e;

  // Result kinds one input may cause, in output order
  typedef enum logic [1:0] {
    ResPrevUp  = 2'd0,
    ResLastUp  = 2'd1,
    ResPrevLow = 2'd2,
    ResLastLow = 2'd3
  } cvr_res_e;

  // One job: window after the shift plus what the back needs to emit its results.
  // win[col][row]: col 0 oldest; row 0 older line, 1 newer line, 2 current pixel.
  typedef struct packed {
    logic [2:0][2:0][PixW-1:0] win;
    logic [3:0]                mask;   // bit i set: result kind i is due
    logic [RowW-1:0]           row;
    logic                      col_ge1;
    logic                      col_ge2;
    logic                      row_ge1;
    logic                      row_ge2;
  } cvr_job_t;

endpackage

>>> hdl/cvr_queue.sv
// Small FIFO carrying jobs from the front to the back.
`timescale 1ns / 1ps
module cvr_queue #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = cvr_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DataW-1:0] push_data_i,
  input  logic             push_i,
  output logic             push_ready_o,
  output logic [DataW-1:0] pop_data_o,
  output logic             pop_valid_o,
  input  logic             pop_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/cvr_front.sv
// Front end: position counters, line store, 3x3 window and result classification.
`timescale 1ns / 1ps
module cvr_front #(
  parameter int unsigned MaxWidth = cvr_pkg::DefaultMaxWidth,
  parameter int unsigned ColW     = $clog2(MaxWidth)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cvr_pkg::FrameWidthW-1:0]   frame_width_i,
  input  logic [cvr_pkg::FrameHeightW-1:0]  frame_height_i,
  input  logic [cvr_pkg::PixW-1:0]          pix_i,
  input  logic                              sof_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  output cvr_pkg::cvr_job_t                 job_o,
  output logic [ColW-1:0]                   job_col_o,
  output logic                              job_valid_o,
  input  logic                              job_ready_i
);
  import cvr_pkg::*;

  // Line store: {newer, older} byte pair per column
  logic [2*PixW-1:0] ls_mem [MaxWidth];
  logic [2*PixW-1:0] rd_q;

  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0] wm1;
  logic [RowW-1:0] hm1;
  logic [ColW-1:0] ic_in;
  logic [RowW-1:0] ir_in;
  logic            row_end_in, last_row_in, accept;

  // Stage A: item between line store read and window update
  logic            a_valid_q;
  logic [PixW-1:0] a_pix_q;
  logic [ColW-1:0] a_col_q;
  logic [RowW-1:0] a_row_q;
  logic            a_row_end_q, a_last_row_q;
  logic            hit_q, hit_d;
  logic [PixW-1:0] fwd_old_q, fwd_new_q;
  logic [PixW-1:0] eff_old, eff_new;
  logic [3:0]      mask;
  logic            a_adv;

  logic [2:0][2:0][PixW-1:0] win_q, win_d;

  // Clamped width-1 and height-1
  always_comb begin
    if (frame_width_i <= FrameWidthW'(1)) begin
      wm1 = '0;
    end else if (32'(frame_width_i) > MaxWidth) begin
      wm1 = ColW'(MaxWidth - 1);
    end else begin
      wm1 = ColW'(frame_width_i - FrameWidthW'(1));
    end
    if (frame_height_i <= FrameHeightW'(1)) begin
      hm1 = '0;
    end else if (32'(frame_height_i) > MaxHeight) begin
      hm1 = RowW'(MaxHeight - 1);
    end else begin
      hm1 = RowW'(frame_height_i - FrameHeightW'(1));
    end
  end

  always_comb begin
    ic_in       = sof_i ? '0 : in_col_q;
    ir_in       = sof_i ? '0 : in_row_q;
    row_end_in  = (ic_in >= wm1);
    last_row_in = (ir_in >= hm1);
    in_col_d    = row_end_in ? '0 : ic_in + 1'b1;
    in_row_d    = row_end_in ? (last_row_in ? '0 : ir_in + 1'b1) : ir_in;
  end

  always_comb begin
    mask[ResPrevUp]  = (a_row_q != '0) && (a_col_q != '0);
    mask[ResLastUp]  = (a_row_q != '0) && a_row_end_q;
    mask[ResPrevLow] = a_last_row_q && (a_col_q != '0);
    mask[ResLastLow] = a_last_row_q && a_row_end_q;
  end

  assign a_adv       = a_valid_q && ((mask == '0) || job_ready_i);
  assign ready_o     = !a_valid_q || a_adv;
  assign accept      = valid_i && ready_o;
  assign job_valid_o = a_valid_q && (mask != '0);

  // Same column read while the previous item writes it back: forward
  assign hit_d   = a_adv && (a_col_q == ic_in);
  assign eff_old = hit_q ? fwd_old_q : rd_q[PixW-1:0];
  assign eff_new = hit_q ? fwd_new_q : rd_q[2*PixW-1:PixW];

  always_comb begin
    win_d[0]    = win_q[1];
    win_d[1]    = win_q[2];
    win_d[2][0] = eff_old;
    win_d[2][1] = eff_new;
    win_d[2][2] = a_pix_q;
  end

  always_comb begin
    job_o.win     = win_d;
    job_o.mask    = mask;
    job_o.row     = a_row_q;
    job_o.col_ge1 = (a_col_q != '0);
    job_o.col_ge2 = (a_col_q >= ColW'(2));
    job_o.row_ge1 = (a_row_q != '0);
    job_o.row_ge2 = (a_row_q >= RowW'(2));
    job_col_o     = a_col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      in_col_q  <= '0;
      in_row_q  <= '0;
      win_q     <= '0;
    end else begin
      if (accept) begin
        in_col_q <= in_col_d;
        in_row_q <= in_row_d;
      end
      if (a_adv) begin
        win_q <= win_d;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q      <= pix_i;
      a_col_q      <= ic_in;
      a_row_q      <= ir_in;
      a_row_end_q  <= row_end_in;
      a_last_row_q <= last_row_in;
      hit_q        <= hit_d;
      fwd_old_q    <= eff_new;
      fwd_new_q    <= a_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= ls_mem[ic_in];
    end
    if (a_adv) begin
      ls_mem[a_col_q] <= {a_pix_q, eff_new};
    end
  end

endmodule

>>> hdl/cvr_back.sv
// Back end: sequences the results of each job and computes the weighted sums.
`timescale 1ns / 1ps
module cvr_back #(
  parameter int unsigned ColW = $clog2(cvr_pkg::DefaultMaxWidth)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [2:0][cvr_pkg::CoefRowW-1:0]       coef_i,
  input  cvr_pkg::cvr_job_t                       job_i,
  input  logic [ColW-1:0]                         job_col_i,
  input  logic                                    job_valid_i,
  output logic                                    job_pop_o,
  output logic signed [cvr_pkg::ValueW-1:0]       value_o,
  output logic [ColW-1:0]                         col_o,
  output logic [cvr_pkg::RowW-1:0]                row_o,
  output logic                                    last_o,
  output logic                                    eof_o,
  output logic                                    valid_o,
  input  logic                                    ready_i
);
  import cvr_pkg::*;

  localparam int unsigned ProdW = PixW + CoefW + 1;
  localparam int unsigned RsumW = ProdW + 2;

  logic [3:0] done_q, done_d, pend, pick, rest;
  cvr_res_e   kind;
  logic       fin, issue, use_last, use_low;
  logic [1:0] cs [3];
  logic [1:0] rs [3];
  logic [2:0][2:0][PixW-1:0] px_sel;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  logic [2:0][2:0][PixW-1:0] px1_q;
  logic [ColW-1:0] col1_q, col2_q, col3_q, col4_q;
  logic [RowW-1:0] row1_q, row2_q, row3_q, row4_q;
  logic            last1_q, last2_q, last3_q, last4_q;
  logic            eof1_q, eof2_q, eof3_q, eof4_q;

  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod2_q [3][3];
  logic signed [RsumW-1:0] rsum_d [3];
  logic signed [RsumW-1:0] rsum3_q [3];
  logic signed [ValueW-1:0] value_d, value4_q;

  assign en4 = !v4_q || ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  // Pick the lowest pending result of the head job
  always_comb begin
    pend = job_i.mask & ~done_q;
    priority case (1'b1)
      pend[ResPrevUp]:  kind = ResPrevUp;
      pend[ResLastUp]:  kind = ResLastUp;
      pend[ResPrevLow]: kind = ResPrevLow;
      default:          kind = ResLastLow;
    endcase
    pick     = 4'b0001 << kind;
    rest     = pend & ~pick;
    fin      = (rest == '0);
    issue    = job_valid_i && en1;
    done_d   = fin ? '0 : (done_q | pick);
    use_last = (kind == ResLastUp) || (kind == ResLastLow);
    use_low  = (kind == ResPrevLow) || (kind == ResLastLow);
  end

  assign job_pop_o = issue && fin;

  // Clamped column and row selection into the window
  always_comb begin
    if (use_last) begin
      cs[0] = job_i.col_ge1 ? 2'd1 : 2'd2;
      cs[1] = 2'd2;
      cs[2] = 2'd2;
    end else begin
      cs[0] = job_i.col_ge2 ? 2'd0 : 2'd1;
      cs[1] = 2'd1;
      cs[2] = 2'd2;
    end
    if (use_low) begin
      rs[0] = job_i.row_ge1 ? 2'd1 : 2'd2;
      rs[1] = 2'd2;
      rs[2] = 2'd2;
    end else begin
      rs[0] = job_i.row_ge2 ? 2'd0 : 2'd1;
      rs[1] = 2'd1;
      rs[2] = 2'd2;
    end
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        px_sel[dy][dx] = job_i.win[cs[dx]][rs[dy]];
      end
    end
  end

  // Nine lanes of pixel times coefficient
  always_comb begin
    logic signed [ProdW-1:0] pa, pb;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        pa = ProdW'({1'b0, px1_q[dy][dx]});
        pb = {{(ProdW-CoefW){coef_i[dy][CoefW*dx+CoefW-1]}}, coef_i[dy][CoefW*dx +: CoefW]};
        prod_d[dy][dx] = pa * pb;
      end
    end
  end

  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      rsum_d[dy] = RsumW'(prod2_q[dy][0]) + RsumW'(prod2_q[dy][1]) + RsumW'(prod2_q[dy][2]);
    end
    value_d = ValueW'(rsum3_q[0]) + ValueW'(rsum3_q[1]) + ValueW'(rsum3_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      if (issue) begin
        done_q <= done_d;
      end
      if (en1) v1_q <= issue;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      px1_q   <= px_sel;
      col1_q  <= use_last ? job_col_i : job_col_i - 1'b1;
      row1_q  <= use_low ? job_i.row : job_i.row - 1'b1;
      last1_q <= fin;
      eof1_q  <= (kind == ResLastLow);
    end
    if (en2) begin
      prod2_q <= prod_d;
      col2_q  <= col1_q;
      row2_q  <= row1_q;
      last2_q <= last1_q;
      eof2_q  <= eof1_q;
    end
    if (en3) begin
      rsum3_q <= rsum_d;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
      last3_q <= last2_q;
      eof3_q  <= eof2_q;
    end
    if (en4) begin
      value4_q <= value_d;
      col4_q   <= col3_q;
      row4_q   <= row3_q;
      last4_q  <= last3_q;
      eof4_q   <= eof3_q;
    end
  end

  assign value_o = value4_q;
  assign col_o   = col4_q;
  assign row_o   = row4_q;
  assign last_o  = last4_q;
  assign eof_o   = eof4_q;
  assign valid_o = v4_q;

endmodule

>>> hdl/conv3x3_replicate_border.sv
// Result path: stage A, job queue, then the select, product, row-sum and value registers.
// Throughput: one pixel per cycle in, one result per cycle out while the output is ready; an
//   input causing two to four results stalls input only once the 4-entry job queue is full.
// Reset (rst_ni, async, active low): counters, window, queue and pipeline cleared;
//   frame size 1x1, coefficients zero. Line store content is undefined until written.
`timescale 1ns / 1ps
module conv3x3_replicate_border #(
  parameter int unsigned MaxWidth = cvr_pkg::DefaultMaxWidth,
  parameter int unsigned ColW     = $clog2(MaxWidth),
  parameter int unsigned OutDataW = ((cvr_pkg::ValueW + ColW + cvr_pkg::RowW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [cvr_pkg::CfgDataW-1:0]  pwdata,
  output logic [cvr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  // pixel stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                    s_axis_tuser,   // [0] start_of_frame
  // result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutDataW-1:0]           m_axis_tdata,   // value, col, row, zero pad
  output logic                          m_axis_tlast,   // last_of_run
  output logic [0:0]                    m_axis_tuser    // [0] end_of_frame
);
  import cvr_pkg::*;

  localparam int unsigned JobW = $bits(cvr_job_t) + ColW;

  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic [2:0][CoefRowW-1:0] coef_q;
  logic                    cfg_wr;
  cvr_reg_e                cfg_idx;

  cvr_job_t        f_job, b_job;
  logic [ColW-1:0] f_col, b_col;
  logic            f_valid, f_ready, b_valid, b_pop;

  logic signed [ValueW-1:0] res_value;
  logic [ColW-1:0]          res_col;
  logic [RowW-1:0]          res_row;
  logic                     res_last, res_eof;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cvr_reg_e'(paddr[CfgAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthW'(1);
      frame_height_q <= FrameHeightW'(1);
      coef_q         <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegFrameWidth:  frame_width_q  <= pwdata[FrameWidthW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[FrameHeightW-1:0];
        RegCoefAbove:   coef_q[0]      <= pwdata[CoefRowW-1:0];
        RegCoefCentre:  coef_q[1]      <= pwdata[CoefRowW-1:0];
        RegCoefBelow:   coef_q[2]      <= pwdata[CoefRowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegFrameWidth:  prdata = CfgDataW'(frame_width_q);
      RegFrameHeight: prdata = CfgDataW'(frame_height_q);
      RegCoefAbove:   prdata = CfgDataW'(coef_q[0]);
      RegCoefCentre:  prdata = CfgDataW'(coef_q[1]);
      RegCoefBelow:   prdata = CfgDataW'(coef_q[2]);
      default:        prdata = '0;
    endcase
  end

  cvr_front #(
    .MaxWidth (MaxWidth),
    .ColW     (ColW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .pix_i          (s_axis_tdata[PixW-1:0]),
    .sof_i          (s_axis_tuser[0]),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .job_o          (f_job),
    .job_col_o      (f_col),
    .job_valid_o    (f_valid),
    .job_ready_i    (f_ready)
  );

  cvr_queue #(
    .DataW (JobW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  ({f_job, f_col}),
    .push_i       (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   ({b_job, b_col}),
    .pop_valid_o  (b_valid),
    .pop_i        (b_pop)
  );

  cvr_back #(
    .ColW (ColW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .job_i       (b_job),
    .job_col_i   (b_col),
    .job_valid_i (b_valid),
    .job_pop_o   (b_pop),
    .value_o     (res_value),
    .col_o       (res_col),
    .row_o       (res_row),
    .last_o      (res_last),
    .eof_o       (res_eof),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = OutDataW'({res_row, res_col, res_value});
  assign m_axis_tlast = res_last;
  assign m_axis_tuser = res_eof;

endmodule

>>> verif/tb_conv3x3_replicate_border.sv
// Self-checking testbench for the 3x3 clamp-to-edge convolution: directed table, then random frames.
`timescale 1ns / 1ps
module tb_conv3x3_replicate_border;
  import cvr_pkg::*;

  localparam int ColBits    = 10;
  localparam int OutW       = ((ValueW + ColBits + RowW + 7) / 8) * 8;
  localparam int MaxCols    = 1024;
  localparam int LatencyPad = 20;
  localparam int CycleLimit = 1000000;
  localparam int NumPhases  = 14;
  localparam int BigPhase   = 5;
  localparam int PausePhase = 8;
  localparam int DirRows    = 26;

  typedef struct {
    logic [ValueW-1:0]  value;
    logic [ColBits-1:0] col;
    logic [RowW-1:0]    row;
    logic               last;
    logic               eof;
  } conv_res_t;

  typedef struct packed {
    logic              is_cfg;
    cvr_reg_e          rsel;
    logic [47:0]       data;
    logic [PixW-1:0]   pix;
    logic              sof;
    logic              has_exp;
    logic [ValueW-1:0] exp_val;   // 1x1 frame only: col 0, row 0, last and end of frame set
  } dir_row_t;

  localparam dir_row_t DirTab [DirRows] = '{
    '{1'b0, RegFrameWidth,  48'h0,              8'h5A, 1'b1, 1'b1, 28'sd0},
    '{1'b1, RegCoefCentre,  48'h0000_0100_0000, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'hFF, 1'b0, 1'b1, 28'sd65280},
    '{1'b1, RegCoefAbove,   48'h8000_8000_8000, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegCoefCentre,  48'h8000_8000_8000, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegCoefBelow,   48'h8000_8000_8000, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'hFF, 1'b1, 1'b1, -28'sd75202560},
    '{1'b1, RegCoefAbove,   48'h7FFF_7FFF_7FFF, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegCoefCentre,  48'h7FFF_7FFF_7FFF, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegCoefBelow,   48'h7FFF_7FFF_7FFF, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'hFF, 1'b0, 1'b1, 28'sd75200265},
    '{1'b1, RegFrameWidth,  48'h0,              8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegFrameHeight, 48'h0,              8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'hFF, 1'b1, 1'b1, 28'sd75200265},
    '{1'b1, RegFrameWidth,  48'd3,              8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegFrameHeight, 48'd3,              8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b1, RegCoefCentre,  48'h0040_FF00_0040, 8'h00, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd10, 1'b1, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd250, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd0,  1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd255, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd128, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd1,  1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd77, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd200, 1'b0, 1'b0, 28'sd0},
    '{1'b0, RegFrameWidth,  48'h0,              8'd33, 1'b0, 1'b0, 28'sd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;    // [7:0] pixel
  logic [0:0]          s_axis_tuser;    // [0] start_of_frame
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;    // [27:0] value, [37:28] col, [49:38] row, zero pad
  logic                m_axis_tlast;    // last_of_run
  logic [0:0]          m_axis_tuser;    // [0] end_of_frame

  // predictor state
  logic [10:0]     width_r;
  logic [12:0]     height_r;
  logic [47:0]     coef_r [3];
  logic [PixW-1:0] line_old [MaxCols];
  logic [PixW-1:0] line_new [MaxCols];
  logic [PixW-1:0] win [3][3];         // win[col][row], col 0 oldest
  int              cur_col;
  int              cur_row;
  conv_res_t       step_out [4];
  conv_res_t       pending_sums [$];

  int  cycles = 0;
  int  err_cnt = 0;
  int  pixels_in = 0;
  int  results_seen = 0;
  int  frames_ended = 0;
  int  reg_writes = 0;
  int  burst_left = 0;
  int  rdy_run = 0;
  bit  gaps_on = 1'b1;
  bit  rx_stall_on = 1'b1;
  bit  sof_due = 1'b0;

  conv3x3_replicate_border dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_sums.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: runs of ready broken by stalls of random length while rx_stall_on is set
  always @(posedge clk_i) begin
    if (rdy_run != 0) begin
      rdy_run <= rdy_run - 1;
    end else if (m_axis_tready && rx_stall_on) begin
      m_axis_tready <= 1'b0;
      rdy_run       <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
      rdy_run       <= $urandom_range(0, 11);
    end
  end

  always @(posedge clk_i) begin
    conv_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[0]) frames_ended++;
      if (pending_sums.size() == 0) begin
        $error("unexpected result: value %0d col %0d row %0d",
               $signed(m_axis_tdata[27:0]), m_axis_tdata[37:28], m_axis_tdata[49:38]);
        err_cnt++;
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata[27:0] !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(m_axis_tdata[27:0]));
          err_cnt++;
        end
        if (m_axis_tdata[37:28] !== want.col) begin
          $error("col: expected %0d, got %0d", want.col, m_axis_tdata[37:28]);
          err_cnt++;
        end
        if (m_axis_tdata[49:38] !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, m_axis_tdata[49:38]);
          err_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tuser[0] !== want.eof) begin
          $error("end_of_frame: expected %0b, got %0b", want.eof, m_axis_tuser[0]);
          err_cnt++;
        end
      end
    end
  end

  function automatic int eff_width(logic [10:0] w);
    return (w == 0) ? 1 : ((w > MaxCols) ? MaxCols : int'(w));
  endfunction

  function automatic int eff_height(logic [12:0] h);
    return (h == 0) ? 1 : ((h > MaxHeight) ? MaxHeight : int'(h));
  endfunction

  // Q20.8 weighted sum (Q8.8 coefficients); c0-c2/r0-r2 pick window columns/rows for offsets -1,0,+1
  function automatic logic [ValueW-1:0] weighted_sum(int c0, int c1, int c2,
                                                     int r0, int r1, int r2);
    int                 cs [3];
    int                 rs [3];
    longint             acc;
    logic signed [15:0] k;
    cs = '{c0, c1, c2};
    rs = '{r0, r1, r2};
    acc = 0;
    for (int dy = 0; dy < 3; dy++)
      for (int dx = 0; dx < 3; dx++) begin
        k = coef_r[dy][16*dx +: 16];
        acc += longint'(win[cs[dx]][rs[dy]]) * longint'(k);
      end
    return acc[ValueW-1:0];
  endfunction

  function automatic void put_res(int n, logic [ValueW-1:0] v, int c, int r);
    step_out[n].value = v;
    step_out[n].col   = c[ColBits-1:0];
    step_out[n].row   = r[RowW-1:0];
    step_out[n].last  = 1'b0;
    step_out[n].eof   = 1'b0;
  endfunction

  // advances the predictor by one pixel; results land in step_out, count returned
  function automatic int conv_step(logic [PixW-1:0] pix, logic sof);
    int w, h, ic, ir, n, prev_l, last_l, up_t, low_t;
    bit row_end, last_row;
    w = eff_width(width_r);
    h = eff_height(height_r);
    if (sof) begin
      cur_col = 0;
      cur_row = 0;
    end
    ic = cur_col;
    ir = cur_row;
    row_end  = ic >= w - 1;
    last_row = ir >= h - 1;
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = line_old[ic];
    win[2][1] = line_new[ic];
    win[2][2] = pix;
    line_old[ic] = line_new[ic];
    line_new[ic] = pix;
    // clamp to edge: at the frame edge the missing neighbour is the nearest one
    prev_l = (ic >= 2) ? 0 : 1;
    last_l = (ic >= 1) ? 1 : 2;
    up_t   = (ir >= 2) ? 0 : 1;
    low_t  = (ir >= 1) ? 1 : 2;
    n = 0;
    if (ir >= 1) begin
      if (ic >= 1) begin
        put_res(n, weighted_sum(prev_l, 1, 2, up_t, 1, 2), ic - 1, ir - 1);
        n++;
      end
      if (row_end) begin
        put_res(n, weighted_sum(last_l, 2, 2, up_t, 1, 2), ic, ir - 1);
        n++;
      end
    end
    if (last_row) begin
      if (ic >= 1) begin
        put_res(n, weighted_sum(prev_l, 1, 2, low_t, 2, 2), ic - 1, ir);
        n++;
      end
      if (row_end) begin
        put_res(n, weighted_sum(last_l, 2, 2, low_t, 2, 2), ic, ir);
        step_out[n].eof = 1'b1;
        n++;
      end
    end
    if (n > 0) step_out[n-1].last = 1'b1;
    if (row_end) begin
      cur_col = 0;
      cur_row = last_row ? 0 : ((ir + 1) & 12'hFFF);
    end else begin
      cur_col = ic + 1;
    end
    return n;
  endfunction

  task automatic write_reg(input cvr_reg_e idx, input logic [47:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      RegFrameWidth: begin
        // a wider frame reads line store columns never written: restart the frame
        if (eff_width(val[10:0]) > eff_width(width_r)) sof_due = 1'b1;
        width_r = val[10:0];
      end
      RegFrameHeight: height_r = val[12:0];
      RegCoefAbove:   coef_r[0] = val;
      RegCoefCentre:  coef_r[1] = val;
      RegCoefBelow:   coef_r[2] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic push_pixel(input logic [PixW-1:0] pix, input logic sof,
                            input bit typed, input logic [ValueW-1:0] typed_val);
    int        n;
    conv_res_t t;
    logic      sof_eff;
    sof_eff = sof | sof_due;
    sof_due = 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof_eff;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_in++;
    n = conv_step(pix, sof_eff);
    if (typed) begin
      t.value = typed_val;
      t.col   = '0;
      t.row   = '0;
      t.last  = 1'b1;
      t.eof   = 1'b1;
      pending_sums = {pending_sums, t};
    end else begin
      for (int i = 0; i < n; i++) pending_sums = {pending_sums, step_out[i]};
    end
  endtask

  // stop sending and let every outstanding result drain, plus the pipeline depth
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (LatencyPad) @(posedge clk_i);
  endtask

  initial begin
    int               n_items, noise_pct, w, h;
    bit               at_start;
    logic             sof;
    logic [PixW-1:0]  pix;
    logic [63:0]      rnd;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    width_r  = 11'd1;
    height_r = 13'd1;
    for (int i = 0; i < 3; i++) begin
      coef_r[i] = '0;
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    for (int i = 0; i < MaxCols; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    cur_col = 0;
    cur_row = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      if (DirTab[i].is_cfg) begin
        settle();
        write_reg(DirTab[i].rsel, DirTab[i].data);
      end else begin
        push_pixel(DirTab[i].pix, DirTab[i].sof, DirTab[i].has_exp, DirTab[i].exp_val);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        2:        w = 0;
        BigPhase: w = 2047;       // saturates to the line store size
        default:  w = $urandom_range(1, 8);
      endcase
      case (ph)
        4:        h = 0;
        BigPhase: h = 2;
        7:        h = 8191;
        10:       h = 1;
        default:  h = $urandom_range(1, 6);
      endcase
      write_reg(RegFrameWidth, 48'(w));
      write_reg(RegFrameHeight, 48'(h));
      for (int r = 0; r < 3; r++) begin
        if (ph == 0 || $urandom_range(0, 1)) begin
          rnd = {$urandom, $urandom};
          if (ph == 11) rnd = (r == 1) ? 64'h7FFF_8000_7FFF : 64'h8000_7FFF_8000;
          write_reg(cvr_reg_e'(int'(RegCoefAbove) + r), rnd[47:0]);
        end
      end
      gaps_on     = (ph % 3) != 2;
      rx_stall_on = (ph % 4) != 1;
      noise_pct   = (ph == BigPhase) ? 0 : 8;
      if (ph == BigPhase)
        n_items = $urandom_range(30, 50);   // start of one long row
      else if (ph == 7)
        n_items = 60;
      else
        n_items = $urandom_range(12, 24);

      for (int k = 0; k < n_items; k++) begin
        if (ph == PausePhase && k == n_items / 2) settle();
        // well-formed framing most of the time; noise gives a restart mid-frame
        // or a dropped start of frame
        at_start = (cur_col == 0) && (cur_row == 0);
        sof = at_start ^ ($urandom_range(0, 99) < noise_pct);
        case ($urandom_range(0, 9))
          0:       pix = 8'h00;
          1:       pix = 8'hFF;
          default: pix = $urandom_range(0, 255);
        endcase
        push_pixel(pix, sof, 1'b0, '0);
      end
    end

    settle();
    $display("Run covered %0d pixels, %0d checked results, %0d frame ends, %0d register writes",
             pixels_in, results_seen, frames_ended, reg_writes);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
